@@ rtl/ldb_pkg.sv @@
package ldb_pkg;

  // Field widths
  localparam int SAMPLE_BITS = 12;
  localparam int TIME_BITS   = 32;
  localparam int MV_BITS     = 12;
  localparam int DUR_BITS    = 16;
  localparam int EVENT_BITS  = 3;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_LEFT_MAX   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RIGHT_MIN  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RIGHT_MAX  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DEBOUNCE   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LONG_PRESS = 3'd4;

  // Configuration reset values
  localparam logic [MV_BITS-1:0]  LEFT_MAX_RST   = 12'd400;
  localparam logic [MV_BITS-1:0]  RIGHT_MIN_RST  = 12'd1200;
  localparam logic [MV_BITS-1:0]  RIGHT_MAX_RST  = 12'd2000;
  localparam logic [DUR_BITS-1:0] DEBOUNCE_RST   = 16'd30;
  localparam logic [DUR_BITS-1:0] LONG_PRESS_RST = 16'd800;

  // Event codes
  localparam logic [EVENT_BITS-1:0] EV_NONE        = 3'd0;
  localparam logic [EVENT_BITS-1:0] EV_LEFT_SHORT  = 3'd1;
  localparam logic [EVENT_BITS-1:0] EV_RIGHT_SHORT = 3'd2;
  localparam logic [EVENT_BITS-1:0] EV_LEFT_LONG   = 3'd3;
  localparam logic [EVENT_BITS-1:0] EV_RIGHT_LONG  = 3'd4;

  typedef enum logic [1:0] {
    BTN_NONE  = 2'd0,
    BTN_LEFT  = 2'd1,
    BTN_RIGHT = 2'd2
  } btn_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample_mv;
    logic [TIME_BITS-1:0]   now_ms;
    logic                   seed;
  } in_t;

  typedef struct packed {
    logic [EVENT_BITS-1:0] event_code;
    logic                  any_held;
  } out_t;

  typedef struct packed {
    logic [MV_BITS-1:0]  left_max_mv;
    logic [MV_BITS-1:0]  right_min_mv;
    logic [MV_BITS-1:0]  right_max_mv;
    logic [DUR_BITS-1:0] debounce_ms;
    logic [DUR_BITS-1:0] long_press_ms;
  } cfg_t;

  typedef struct packed {
    btn_t                 committed_button;
    btn_t                 seen_button;
    logic [TIME_BITS-1:0] change_time;
    logic [TIME_BITS-1:0] press_time;
    logic                 long_done;
  } st_t;

endpackage

@@ rtl/ladder_button_debounce_press.sv @@
// Channel  | Direction | Handshake              | Payload
// in_      | input     | in_valid / in_stall    | in_data  (sample_mv, now_ms, seed)
// out_     | output    | out_valid / out_stall  | out_data (event_code, any_held)
// cfg_     | input     | cfg_we                 | cfg_index, cfg_data
//
// One item per cycle sustained while out_stall is low; each item passes
// through the input register, then the result register, before out_valid
// for it rises, and its result transfers while out_stall is low.
// The debounce state updates as an item moves from the input register to
// the result register, so items are processed strictly in order.
// rst_n is synchronous: it clears both valid flags, the debounce state and
// loads the default thresholds and times.
// A stalled result holds in place; the input register takes one more item
// behind it, then in_stall stays high until the result transfers.
module ladder_button_debounce_press (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  ldb_pkg::in_t                        in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output ldb_pkg::out_t                       out_data,
  input  logic                                cfg_we,
  input  logic [ldb_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [ldb_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  ldb_pkg::cfg_t cfg_r;
  ldb_pkg::st_t  st_r;
  ldb_pkg::st_t  st_nxt;
  ldb_pkg::in_t  item_r;
  logic          item_valid_r;
  ldb_pkg::out_t res_nxt;
  ldb_pkg::out_t res_r;
  logic          res_valid_r;
  logic          res_free;
  logic          advance;
  logic          take;

  // Handshake control
  assign res_free = !res_valid_r || !out_stall;
  assign advance  = item_valid_r && res_free;
  assign take     = in_valid && !in_stall;
  assign in_stall = item_valid_r && !res_free;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.left_max_mv   <= ldb_pkg::LEFT_MAX_RST;
      cfg_r.right_min_mv  <= ldb_pkg::RIGHT_MIN_RST;
      cfg_r.right_max_mv  <= ldb_pkg::RIGHT_MAX_RST;
      cfg_r.debounce_ms   <= ldb_pkg::DEBOUNCE_RST;
      cfg_r.long_press_ms <= ldb_pkg::LONG_PRESS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ldb_pkg::CFG_LEFT_MAX:   cfg_r.left_max_mv   <= cfg_data[ldb_pkg::MV_BITS-1:0];
        ldb_pkg::CFG_RIGHT_MIN:  cfg_r.right_min_mv  <= cfg_data[ldb_pkg::MV_BITS-1:0];
        ldb_pkg::CFG_RIGHT_MAX:  cfg_r.right_max_mv  <= cfg_data[ldb_pkg::MV_BITS-1:0];
        ldb_pkg::CFG_DEBOUNCE:   cfg_r.debounce_ms   <= cfg_data[ldb_pkg::DUR_BITS-1:0];
        ldb_pkg::CFG_LONG_PRESS: cfg_r.long_press_ms <= cfg_data[ldb_pkg::DUR_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Capture each transfer in the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (take) begin
      item_valid_r <= 1'b1;
    end else if (advance) begin
      item_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= in_data;
    end
  end

  ldb_step u_step (
    .cfg    (cfg_r),
    .st     (st_r),
    .item   (item_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  // Commit state and load the result register as an item advances
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.committed_button <= ldb_pkg::BTN_NONE;
      st_r.seen_button      <= ldb_pkg::BTN_NONE;
      st_r.change_time      <= '0;
      st_r.press_time       <= '0;
      st_r.long_done        <= 1'b0;
      res_valid_r           <= 1'b0;
    end else begin
      if (advance) begin
        st_r        <= st_nxt;
        res_valid_r <= 1'b1;
      end else if (res_free) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = res_valid_r;
  assign out_data  = res_r;

endmodule

@@ rtl/ldb_step.sv @@
module ldb_step (
  input  ldb_pkg::cfg_t cfg,
  input  ldb_pkg::st_t  st,
  input  ldb_pkg::in_t  item,
  output ldb_pkg::st_t  st_nxt,
  output ldb_pkg::out_t res
);

  ldb_pkg::btn_t                 cur;
  logic [ldb_pkg::TIME_BITS-1:0] el_change;
  logic [ldb_pkg::TIME_BITS-1:0] el_press;
  logic [ldb_pkg::TIME_BITS-1:0] deb_ext;
  logic [ldb_pkg::TIME_BITS-1:0] long_ext;
  logic                          settling;
  logic                          long_due;
  logic [ldb_pkg::EVENT_BITS-1:0] ev;

  // Classify the sample; left wins where bands overlap
  always_comb begin
    if (item.sample_mv <= cfg.left_max_mv) begin
      cur = ldb_pkg::BTN_LEFT;
    end else if (item.sample_mv >= cfg.right_min_mv &&
                 item.sample_mv <= cfg.right_max_mv) begin
      cur = ldb_pkg::BTN_RIGHT;
    end else begin
      cur = ldb_pkg::BTN_NONE;
    end
  end

  // Wrapping elapsed times against the configured durations
  assign deb_ext  = {{(ldb_pkg::TIME_BITS-ldb_pkg::DUR_BITS){1'b0}}, cfg.debounce_ms};
  assign long_ext = {{(ldb_pkg::TIME_BITS-ldb_pkg::DUR_BITS){1'b0}}, cfg.long_press_ms};
  assign el_change = item.now_ms - st.change_time;
  assign el_press  = item.now_ms - st.press_time;
  assign settling  = (el_change < deb_ext) || (cur == st.committed_button);
  assign long_due  = (st.committed_button != ldb_pkg::BTN_NONE) && !st.long_done &&
                     (el_press >= long_ext);

  // Advance the debounce state by one sample
  always_comb begin
    st_nxt = st;
    ev     = ldb_pkg::EV_NONE;
    if (item.seed) begin
      st_nxt.committed_button = cur;
      st_nxt.seen_button      = cur;
      st_nxt.change_time      = item.now_ms;
      st_nxt.press_time       = item.now_ms;
      st_nxt.long_done        = (cur != ldb_pkg::BTN_NONE);
    end else if (cur != st.seen_button) begin
      st_nxt.seen_button = cur;
      st_nxt.change_time = item.now_ms;
    end else if (settling) begin
      if (long_due) begin
        st_nxt.long_done = 1'b1;
        ev = (st.committed_button == ldb_pkg::BTN_LEFT) ? ldb_pkg::EV_LEFT_LONG
                                                         : ldb_pkg::EV_RIGHT_LONG;
      end
    end else begin
      st_nxt.committed_button = cur;
      if (cur != ldb_pkg::BTN_NONE) begin
        st_nxt.press_time = item.now_ms;
        st_nxt.long_done  = 1'b0;
      end else if (!st.long_done && st.committed_button != ldb_pkg::BTN_NONE) begin
        ev = (st.committed_button == ldb_pkg::BTN_LEFT) ? ldb_pkg::EV_LEFT_SHORT
                                                         : ldb_pkg::EV_RIGHT_SHORT;
      end
    end
  end

  assign res.event_code = ev;
  assign res.any_held   = (st_nxt.committed_button != ldb_pkg::BTN_NONE);

endmodule

@@ rtl/ldb_checker.sv @@
module ldb_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          out_valid,
  input logic          out_stall,
  input ldb_pkg::out_t out_data
);

  // No result survives reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Only defined event codes
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.event_code == ldb_pkg::EV_NONE ||
                   out_data.event_code == ldb_pkg::EV_LEFT_SHORT ||
                   out_data.event_code == ldb_pkg::EV_RIGHT_SHORT ||
                   out_data.event_code == ldb_pkg::EV_LEFT_LONG ||
                   out_data.event_code == ldb_pkg::EV_RIGHT_LONG))
    else $error("undefined event code");

  // A long press fires while the button is still held
  a_long_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.event_code == ldb_pkg::EV_LEFT_LONG ||
                  out_data.event_code == ldb_pkg::EV_RIGHT_LONG) |-> out_data.any_held)
    else $error("long event without held button");

  // A short press fires only on release
  a_short_rel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.event_code == ldb_pkg::EV_LEFT_SHORT ||
                  out_data.event_code == ldb_pkg::EV_RIGHT_SHORT) |-> !out_data.any_held)
    else $error("short event while button held");

endmodule

bind ladder_button_debounce_press ldb_checker u_ldb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
